/* rtl/core/midi_file_stream_parser_core_macros.svh */
// Assertion macros for the MIDI file stream parser core.
`ifndef MIDI_FILE_STREAM_PARSER_CORE_MACROS_SVH
`define MIDI_FILE_STREAM_PARSER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define MFSP_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mfsp check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define MFSP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mfsp check failed");

`endif

/* rtl/core/mfsp_pkg.sv */
// Types, codes and marker tables for the MIDI file stream parser core.
package mfsp_pkg;

  localparam int unsigned MAX_DELTA_BYTES_DEF = 4;

  localparam logic [7:0] META_STATUS   = 8'hFF;
  localparam logic [7:0] META_TRK_END  = 8'h2F;
  localparam logic [7:0] HDR_SIZE_LAST = 8'h06;

  typedef enum logic [3:0] {
    PH_HMARK  = 4'd0,
    PH_HSIZE  = 4'd1,
    PH_HDATA  = 4'd2,
    PH_TMARK  = 4'd3,
    PH_TLEN   = 4'd4,
    PH_DELTA  = 4'd5,
    PH_STATUS = 4'd6,
    PH_P1     = 4'd7,
    PH_P2     = 4'd8,
    PH_MTYPE  = 4'd9,
    PH_MLEN   = 4'd10,
    PH_MSKIP  = 4'd11
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_CHANNEL = 2'd1,
    KIND_TRK_END = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_NO_MTHD    = 3'd1,
    ERR_BAD_SIZE   = 3'd2,
    ERR_BAD_FORMAT = 3'd3,
    ERR_TRK_COUNT  = 3'd4,
    ERR_NO_MTRK    = 3'd5,
    ERR_TRUNCATED  = 3'd6,
    ERR_DELTA_LONG = 3'd7
  } err_e;

  localparam logic [3:0] CODE_PROG_CHG = 4'hC;
  localparam logic [3:0] CODE_CH_PRESS = 4'hD;

  // format_held code for anything other than 0 or 1
  localparam logic [1:0] FMT_INVALID = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_beat_t;

  typedef struct packed {
    kind_e       kind;
    logic        file_format;
    logic [15:0] track_total;
    logic [15:0] ticks_per_quarter;
    logic [27:0] delta_time;
    logic [3:0]  event_code;
    logic [3:0]  channel_number;
    logic [7:0]  first_param;
    logic [7:0]  second_param;
    err_e        error_code;
  } out_beat_t;

  // "MThd"
  function automatic logic [7:0] head_mark(input logic [1:0] pos);
    logic [7:0] r;
    case (pos)
      2'd0:    r = 8'h4D;
      2'd1:    r = 8'h54;
      2'd2:    r = 8'h68;
      default: r = 8'h64;
    endcase
    return r;
  endfunction

  // "MTrk"
  function automatic logic [7:0] track_mark(input logic [1:0] pos);
    logic [7:0] r;
    case (pos)
      2'd0:    r = 8'h4D;
      2'd1:    r = 8'h54;
      2'd2:    r = 8'h72;
      default: r = 8'h6B;
    endcase
    return r;
  endfunction

  // big-endian header length 6
  function automatic logic [7:0] size_byte(input logic [1:0] pos);
    return (pos == 2'd3) ? HDR_SIZE_LAST : 8'h00;
  endfunction

endpackage

/* rtl/core/midi_file_stream_parser_core.sv */
// Byte-serial Standard MIDI File parser: header, track markers, delta times, events.
//
//   channel | dir | handshake               | payload
//   in      | in  | in_valid_i / in_ready_o | in_data_i  (mfsp_pkg::in_beat_t)
//   out     | out | out_valid_o/out_ready_i | out_data_o (mfsp_pkg::out_beat_t)
//
// One byte per cycle unless the result side stalls; a byte may yield no result.
// Path: input register -> one pass of parser logic -> result register.
// A stalled result holds; the input register takes one more byte, then ready drops.
// Reset clears the parser to "expect MThd"; no clearing pass.
// A byte flagged end_of_file returns the parser to its reset state after that byte.
`include "midi_file_stream_parser_core_macros.svh"

module midi_file_stream_parser_core #(
  parameter int unsigned MAX_DELTA_BYTES = mfsp_pkg::MAX_DELTA_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mfsp_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mfsp_pkg::out_beat_t out_data_o
);

  // input stage
  logic               in_valid_q;
  mfsp_pkg::in_beat_t in_q;
  logic               advance;
  logic               step;

  // parser state
  mfsp_pkg::phase_e phase_q, phase_d;
  logic [2:0]       fpos_q, fpos_d;
  logic [27:0]      acc_q, acc_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [1:0]       fmt_q, fmt_d;
  logic [15:0]      trk_q, trk_d;
  logic [15:0]      div_q, div_d;
  logic [7:0]       stat_q, stat_d;
  logic [7:0]       prm_q, prm_d;
  logic [7:0]       skip_q, skip_d;
  logic             halt_q, halt_d;

  // result stage
  logic                out_valid_q;
  mfsp_pkg::out_beat_t out_q;
  mfsp_pkg::out_beat_t res;
  logic                res_v;

  // scratch
  logic [7:0]     b;
  logic [1:0]     mpos;
  logic [2:0]     cnt_inc;
  logic           fail;
  mfsp_pkg::err_e fcode;
  logic           meta_end;

  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  always_comb begin
    b        = in_q.data_byte;
    phase_d  = phase_q;
    fpos_d   = fpos_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    fmt_d    = fmt_q;
    trk_d    = trk_q;
    div_d    = div_q;
    stat_d   = stat_q;
    prm_d    = prm_q;
    skip_d   = skip_q;
    halt_d   = halt_q;
    res      = '0;
    res_v    = 1'b0;
    fail     = 1'b0;
    fcode    = mfsp_pkg::ERR_NONE;
    meta_end = 1'b0;
    mpos     = (fpos_q > 3'd3) ? 2'd3 : fpos_q[1:0];
    cnt_inc  = cnt_q + 3'd1;

    if (!halt_q) begin
      case (phase_q)
        mfsp_pkg::PH_HMARK, mfsp_pkg::PH_HSIZE, mfsp_pkg::PH_TMARK: begin
          if (phase_q == mfsp_pkg::PH_HMARK && b != mfsp_pkg::head_mark(mpos)) begin
            fail  = 1'b1;
            fcode = mfsp_pkg::ERR_NO_MTHD;
          end else if (phase_q == mfsp_pkg::PH_HSIZE && b != mfsp_pkg::size_byte(mpos)) begin
            fail  = 1'b1;
            fcode = mfsp_pkg::ERR_BAD_SIZE;
          end else if (phase_q == mfsp_pkg::PH_TMARK && b != mfsp_pkg::track_mark(mpos)) begin
            fail  = 1'b1;
            fcode = mfsp_pkg::ERR_NO_MTRK;
          end else if (mpos == 2'd3) begin
            fpos_d = '0;
            if (phase_q == mfsp_pkg::PH_HMARK) begin
              phase_d = mfsp_pkg::PH_HSIZE;
            end else if (phase_q == mfsp_pkg::PH_HSIZE) begin
              phase_d = mfsp_pkg::PH_HDATA;
            end else begin
              phase_d = mfsp_pkg::PH_TLEN;
            end
          end else begin
            fpos_d = {1'b0, mpos} + 3'd1;
          end
        end
        mfsp_pkg::PH_HDATA: begin
          fpos_d = fpos_q + 3'd1;
          case (fpos_q)
            3'd0: fmt_d = (b != 8'h00) ? mfsp_pkg::FMT_INVALID : 2'd0;
            3'd1: begin
              if (fmt_q != mfsp_pkg::FMT_INVALID) begin
                fmt_d = (b <= 8'd1) ? {1'b0, b[0]} : mfsp_pkg::FMT_INVALID;
              end
            end
            3'd2: trk_d = {b, 8'h00};
            3'd3: trk_d = {trk_q[15:8], b};
            3'd4: div_d = {b, 8'h00};
            default: begin
              // last header byte: position stays on it unless the header is accepted
              fpos_d = fpos_q;
              div_d  = {div_q[15:8], b};
              if (fmt_q == mfsp_pkg::FMT_INVALID) begin
                fail  = 1'b1;
                fcode = mfsp_pkg::ERR_BAD_FORMAT;
              end else if (fmt_q == 2'd0 && trk_q != 16'd1) begin
                fail  = 1'b1;
                fcode = mfsp_pkg::ERR_TRK_COUNT;
              end else begin
                res_v                 = 1'b1;
                res.kind              = mfsp_pkg::KIND_HEADER;
                res.file_format       = fmt_q[0];
                res.track_total       = trk_q;
                res.ticks_per_quarter = {div_q[15:8], b};
                phase_d               = mfsp_pkg::PH_TMARK;
                fpos_d                = '0;
              end
            end
          endcase
        end
        mfsp_pkg::PH_TLEN: begin
          if (fpos_q >= 3'd3) begin
            fpos_d  = '0;
            phase_d = mfsp_pkg::PH_DELTA;
            acc_d   = '0;
            cnt_d   = '0;
          end else begin
            fpos_d = fpos_q + 3'd1;
          end
        end
        mfsp_pkg::PH_DELTA: begin
          acc_d = {acc_q[20:0], b[6:0]};
          cnt_d = cnt_inc;
          if (b[7]) begin
            // continuation on the last allowed byte, or count wrapped
            if ({1'b0, cnt_inc} >= 4'(MAX_DELTA_BYTES) || cnt_inc == 3'd0) begin
              fail  = 1'b1;
              fcode = mfsp_pkg::ERR_DELTA_LONG;
            end
          end else begin
            phase_d = mfsp_pkg::PH_STATUS;
          end
        end
        mfsp_pkg::PH_STATUS: begin
          if (b == mfsp_pkg::META_STATUS) begin
            phase_d = mfsp_pkg::PH_MTYPE;
          end else begin
            stat_d  = b;
            phase_d = mfsp_pkg::PH_P1;
          end
        end
        mfsp_pkg::PH_P1, mfsp_pkg::PH_P2: begin
          if (phase_q == mfsp_pkg::PH_P1) begin
            prm_d = b;
          end
          if (phase_q == mfsp_pkg::PH_P2 || stat_q[7:4] == mfsp_pkg::CODE_PROG_CHG ||
              stat_q[7:4] == mfsp_pkg::CODE_CH_PRESS) begin
            res_v              = 1'b1;
            res.kind           = mfsp_pkg::KIND_CHANNEL;
            res.delta_time     = acc_q;
            res.event_code     = stat_q[7:4];
            res.channel_number = stat_q[3:0];
            res.first_param    = (phase_q == mfsp_pkg::PH_P1) ? b : prm_q;
            res.second_param   = (phase_q == mfsp_pkg::PH_P2) ? b : 8'h00;
            phase_d            = mfsp_pkg::PH_DELTA;
            acc_d              = '0;
            cnt_d              = '0;
          end else begin
            phase_d = mfsp_pkg::PH_P2;
          end
        end
        mfsp_pkg::PH_MTYPE: begin
          prm_d   = b;
          phase_d = mfsp_pkg::PH_MLEN;
        end
        mfsp_pkg::PH_MLEN: begin
          skip_d = b;
          if (b == 8'h00) begin
            meta_end = 1'b1;
          end else begin
            phase_d = mfsp_pkg::PH_MSKIP;
          end
        end
        mfsp_pkg::PH_MSKIP: begin
          skip_d = skip_q - 8'd1;
          if (skip_q == 8'd1) begin
            meta_end = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (meta_end) begin
      if (prm_q == mfsp_pkg::META_TRK_END) begin
        res_v          = 1'b1;
        res.kind       = mfsp_pkg::KIND_TRK_END;
        res.delta_time = acc_q;
        phase_d        = mfsp_pkg::PH_TMARK;
        fpos_d         = '0;
      end else begin
        phase_d = mfsp_pkg::PH_DELTA;
        acc_d   = '0;
        cnt_d   = '0;
      end
    end

    if (fail) begin
      res            = '0;
      res.kind       = mfsp_pkg::KIND_ERROR;
      res.error_code = fcode;
      res_v          = 1'b1;
      halt_d         = 1'b1;
    end

    if (in_q.end_of_file) begin
      // clean end only when waiting at the start of a new MTrk
      if (!halt_d && !(phase_d == mfsp_pkg::PH_TMARK && fpos_d == 3'd0)) begin
        res            = '0;
        res.kind       = mfsp_pkg::KIND_ERROR;
        res.error_code = mfsp_pkg::ERR_TRUNCATED;
        res_v          = 1'b1;
      end
      phase_d = mfsp_pkg::PH_HMARK;
      fpos_d  = '0;
      acc_d   = '0;
      cnt_d   = '0;
      fmt_d   = '0;
      trk_d   = '0;
      div_d   = '0;
      stat_d  = '0;
      prm_d   = '0;
      skip_d  = '0;
      halt_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mfsp_pkg::PH_HMARK;
      fpos_q  <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
      fmt_q   <= '0;
      trk_q   <= '0;
      div_q   <= '0;
      stat_q  <= '0;
      prm_q   <= '0;
      skip_q  <= '0;
      halt_q  <= 1'b0;
    end else if (step) begin
      phase_q <= phase_d;
      fpos_q  <= fpos_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      fmt_q   <= fmt_d;
      trk_q   <= trk_d;
      div_q   <= div_d;
      stat_q  <= stat_d;
      prm_q   <= prm_d;
      skip_q  <= skip_d;
      halt_q  <= halt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && res_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_v) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // error beats always carry a code
  `MFSP_ASSERT_NOW(a_err_has_code, out_valid_q && out_q.kind == mfsp_pkg::KIND_ERROR, out_q.error_code != mfsp_pkg::ERR_NONE)
  // a halted parser produces nothing
  `MFSP_ASSERT_NEXT(a_halt_silent, step && halt_q, !out_valid_q)
  // a held byte is not dropped while the result side is stalled
  `MFSP_ASSERT_NEXT(a_in_hold, in_valid_q && !advance, in_valid_q)
  // field position never runs past the last header data byte
  `MFSP_ASSERT_NOW(a_fpos_range, 1'b1, fpos_q <= 3'd5)

endmodule

/* test/mfsp_event_checker.sv */
// Checker for the MIDI file parser: predicts each byte's result and compares output beats.
`timescale 1ns / 1ps

module mfsp_event_checker #(
  parameter int unsigned MAX_DELTA_BYTES = mfsp_pkg::MAX_DELTA_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  mfsp_pkg::in_beat_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  mfsp_pkg::out_beat_t out_data_i,
  output int                  mismatches_o,
  output int                  pending_o
);

  localparam logic [31:0] MTHD_TAG = "MThd";
  localparam logic [31:0] HDR_LEN  = 32'd6;
  localparam logic [31:0] MTRK_TAG = "MTrk";

  mfsp_pkg::phase_e pstate;
  logic [2:0]  fpos;
  logic [27:0] delta_acc;
  logic [2:0]  delta_cnt;
  logic [1:0]  fmt;
  logic [15:0] ntracks;
  logic [15:0] division;
  logic [7:0]  status;
  logic [7:0]  param;      // meta type while inside a meta event
  logic [7:0]  skip;
  logic        stalled;

  mfsp_pkg::out_beat_t expected_events[$];

  function automatic void clear_parser();
    pstate    = mfsp_pkg::PH_HMARK;
    fpos      = '0;
    delta_acc = '0;
    delta_cnt = '0;
    fmt       = '0;
    ntracks   = '0;
    division  = '0;
    status    = '0;
    param     = '0;
    skip      = '0;
    stalled   = 1'b0;
  endfunction

  function automatic void start_event();
    pstate    = mfsp_pkg::PH_DELTA;
    delta_acc = '0;
    delta_cnt = '0;
  endfunction

  function automatic bit raise_error(input mfsp_pkg::err_e code,
                                     output mfsp_pkg::out_beat_t res);
    res            = '0;
    res.kind       = mfsp_pkg::KIND_ERROR;
    res.error_code = code;
    stalled        = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit emit_channel(input logic [7:0] second,
                                      output mfsp_pkg::out_beat_t res);
    res                = '0;
    res.kind           = mfsp_pkg::KIND_CHANNEL;
    res.delta_time     = delta_acc;
    res.event_code     = status[7:4];
    res.channel_number = status[3:0];
    res.first_param    = param;
    res.second_param   = second;
    start_event();
    return 1'b1;
  endfunction

  function automatic bit end_meta(output mfsp_pkg::out_beat_t res);
    res = '0;
    if (param == mfsp_pkg::META_TRK_END) begin
      res.kind       = mfsp_pkg::KIND_TRK_END;
      res.delta_time = delta_acc;
      pstate         = mfsp_pkg::PH_TMARK;
      fpos           = '0;
      return 1'b1;
    end
    start_event();
    return 1'b0;
  endfunction

  // Advance the parser by one byte; returns 1 when the byte yields a result.
  function automatic bit parse_byte(input mfsp_pkg::in_beat_t beat,
                                    output mfsp_pkg::out_beat_t res);
    logic [7:0]     b;
    logic [2:0]     pos;
    logic [31:0]    tag;
    mfsp_pkg::err_e code;
    bit             got;
    b   = beat.data_byte;
    pos = fpos;
    res = '0;
    got = 1'b0;
    if (!stalled) begin
      case (pstate)
        mfsp_pkg::PH_HMARK, mfsp_pkg::PH_HSIZE, mfsp_pkg::PH_TMARK: begin
          if (pos > 3'd3) pos = 3'd3;
          case (pstate)
            mfsp_pkg::PH_HMARK: begin
              tag  = MTHD_TAG;
              code = mfsp_pkg::ERR_NO_MTHD;
            end
            mfsp_pkg::PH_HSIZE: begin
              tag  = HDR_LEN;
              code = mfsp_pkg::ERR_BAD_SIZE;
            end
            default: begin
              tag  = MTRK_TAG;
              code = mfsp_pkg::ERR_NO_MTRK;
            end
          endcase
          if (b != tag[8*(3-pos) +: 8]) begin
            got = raise_error(code, res);
          end else if (pos == 3'd3) begin
            pstate = mfsp_pkg::phase_e'(pstate + 4'd1);
            fpos   = '0;
          end else begin
            fpos = pos + 3'd1;
          end
        end
        mfsp_pkg::PH_HDATA: begin
          case (pos)
            3'd0: fmt = (b != 8'd0) ? mfsp_pkg::FMT_INVALID : 2'd0;
            3'd1: begin
              if (fmt != mfsp_pkg::FMT_INVALID)
                fmt = (b <= 8'd1) ? b[1:0] : mfsp_pkg::FMT_INVALID;
            end
            3'd2: ntracks = {b, 8'h00};
            3'd3: ntracks = ntracks | {8'h00, b};
            3'd4: division = {b, 8'h00};
            default: begin
              division = division | {8'h00, b};
              if (fmt == mfsp_pkg::FMT_INVALID) begin
                got = raise_error(mfsp_pkg::ERR_BAD_FORMAT, res);
              end else if (fmt == 2'd0 && ntracks != 16'd1) begin
                got = raise_error(mfsp_pkg::ERR_TRK_COUNT, res);
              end else begin
                res.kind              = mfsp_pkg::KIND_HEADER;
                res.file_format       = fmt[0];
                res.track_total       = ntracks;
                res.ticks_per_quarter = division;
                pstate                = mfsp_pkg::PH_TMARK;
                fpos                  = '0;
                got                   = 1'b1;
              end
            end
          endcase
          if (pos < 3'd5) fpos = pos + 3'd1;
        end
        mfsp_pkg::PH_TLEN: begin
          if (pos >= 3'd3) begin
            fpos = '0;
            start_event();
          end else begin
            fpos = pos + 3'd1;
          end
        end
        mfsp_pkg::PH_DELTA: begin
          delta_acc = {delta_acc[20:0], b[6:0]};
          delta_cnt = delta_cnt + 3'd1;
          if (b[7]) begin
            if (delta_cnt >= MAX_DELTA_BYTES || delta_cnt == 3'd0)
              got = raise_error(mfsp_pkg::ERR_DELTA_LONG, res);
          end else begin
            pstate = mfsp_pkg::PH_STATUS;
          end
        end
        mfsp_pkg::PH_STATUS: begin
          if (b == mfsp_pkg::META_STATUS) begin
            pstate = mfsp_pkg::PH_MTYPE;
          end else begin
            status = b;
            pstate = mfsp_pkg::PH_P1;
          end
        end
        mfsp_pkg::PH_P1: begin
          param = b;
          if (status[7:4] == mfsp_pkg::CODE_PROG_CHG ||
              status[7:4] == mfsp_pkg::CODE_CH_PRESS)
            got = emit_channel(8'h00, res);
          else
            pstate = mfsp_pkg::PH_P2;
        end
        mfsp_pkg::PH_P2: got = emit_channel(b, res);
        mfsp_pkg::PH_MTYPE: begin
          param  = b;
          pstate = mfsp_pkg::PH_MLEN;
        end
        mfsp_pkg::PH_MLEN: begin
          skip = b;
          if (b == 8'd0) got = end_meta(res);
          else pstate = mfsp_pkg::PH_MSKIP;
        end
        mfsp_pkg::PH_MSKIP: begin
          skip = skip - 8'd1;
          if (skip == 8'd0) got = end_meta(res);
        end
        default: ;
      endcase
    end
    // the flagged last byte must leave the parser waiting for a fresh MTrk
    if (beat.end_of_file) begin
      if (!stalled && !(pstate == mfsp_pkg::PH_TMARK && fpos == 3'd0))
        got = raise_error(mfsp_pkg::ERR_TRUNCATED, res);
      clear_parser();
    end
    return got;
  endfunction

  function automatic bit events_differ(input mfsp_pkg::out_beat_t e,
                                       input mfsp_pkg::out_beat_t g);
    return (e.kind !== g.kind) || (e.file_format !== g.file_format) ||
           (e.track_total !== g.track_total) ||
           (e.ticks_per_quarter !== g.ticks_per_quarter) ||
           (e.delta_time !== g.delta_time) || (e.event_code !== g.event_code) ||
           (e.channel_number !== g.channel_number) ||
           (e.first_param !== g.first_param) || (e.second_param !== g.second_param) ||
           (e.error_code !== g.error_code);
  endfunction

  function automatic string describe(input mfsp_pkg::out_beat_t e);
    return $sformatf({"kind=%0d fmt=%0d tracks=%0d tpq=%0d delta=%0d ",
                      "code=%h ch=%h p1=%h p2=%h err=%0d"},
                     e.kind, e.file_format, e.track_total, e.ticks_per_quarter,
                     e.delta_time, e.event_code, e.channel_number, e.first_param,
                     e.second_param, e.error_code);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    mfsp_pkg::out_beat_t res;
    mfsp_pkg::out_beat_t want;
    if (!rst_ni) begin
      clear_parser();
      expected_events.delete();
      mismatches_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (parse_byte(in_data_i, res)) expected_events.push_back(res);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_events.size() == 0) begin
          if (mismatches_o < 10)
            $display("%0t: unexpected result beat: %s", $time, describe(out_data_i));
          mismatches_o++;
        end else begin
          want = expected_events.pop_front();
          if (events_differ(want, out_data_i)) begin
            if (mismatches_o < 10)
              $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                       $time, describe(want), describe(out_data_i));
            mismatches_o++;
          end
        end
      end
    end
    pending_o = expected_events.size();
  end

endmodule

/* test/tb_midi_file_stream_parser_core.sv */
// Testbench top for the MIDI file parser core: builds byte streams and gives the verdict.
`timescale 1ns / 1ps

module tb_midi_file_stream_parser_core;

  localparam logic [31:0] MTHD_TAG = "MThd";
  localparam logic [31:0] HDR_LEN  = 32'd6;
  localparam logic [31:0] MTRK_TAG = "MTrk";
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_BEATS    = 650;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  mfsp_pkg::in_beat_t  in_data;
  logic                out_valid;
  logic                out_ready;
  mfsp_pkg::out_beat_t out_data;
  int                  mismatches;
  int                  pending;

  int tx_idle_pct = 32;
  int rx_idle_pct = 54;
  bit hold_go     = 1'b0;
  int beats_sent  = 0;
  int idle_cycles = 0;

  mfsp_pkg::in_beat_t file_beats[$];

  midi_file_stream_parser_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  mfsp_event_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic put(input logic [7:0] b);
    mfsp_pkg::in_beat_t beat;
    beat.data_byte   = b;
    beat.end_of_file = 1'b0;
    file_beats.push_back(beat);
  endtask

  task automatic put_tag(input logic [31:0] t);
    for (int i = 3; i >= 0; i--) put(t[8*i +: 8]);
  endtask

  // flag the last queued byte as end of file
  task automatic finish_file();
    mfsp_pkg::in_beat_t beat;
    beat = file_beats.pop_back();
    beat.end_of_file = 1'b1;
    file_beats.push_back(beat);
  endtask

  task automatic put_delta();
    int         n;
    int         style;
    logic [7:0] b;
    n = $urandom_range(4, 1);
    if ($urandom_range(29) == 0) n = 5;   // one continuation too many
    style = $urandom_range(7);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(255));
      if (style == 0) b = 8'hFF;
      else if (style == 1) b = 8'h00;
      b[7] = (i < n - 1);
      put(b);
    end
  endtask

  task automatic put_event();
    logic [7:0] st;
    int         len;
    put_delta();
    if ($urandom_range(3) == 0) begin
      put(mfsp_pkg::META_STATUS);
      st = 8'($urandom_range(255));
      if (st == mfsp_pkg::META_TRK_END) st = 8'h01;
      put(st);
      len = $urandom_range(5);
      put(len[7:0]);
      repeat (len) put(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(7) == 0) st = 8'($urandom_range(254));
      else st = {4'($urandom_range(14, 8)), 4'($urandom_range(15))};
      put(st);
      put(8'($urandom_range(255)));
      if (st[7:4] != mfsp_pkg::CODE_PROG_CHG && st[7:4] != mfsp_pkg::CODE_CH_PRESS)
        put(8'($urandom_range(255)));
    end
  endtask

  task automatic put_track_end();
    int len;
    put_delta();
    put(mfsp_pkg::META_STATUS);
    put(mfsp_pkg::META_TRK_END);
    len = ($urandom_range(4) == 0) ? $urandom_range(3, 1) : 0;
    put(len[7:0]);
    repeat (len) put(8'($urandom_range(255)));
  endtask

  task automatic build_midi_file();
    int                 sel;
    int                 hdr_tracks;
    int                 body_tracks;
    int                 cut;
    int                 idx;
    logic [7:0]         f0;
    logic [7:0]         f1;
    logic [15:0]        div;
    mfsp_pkg::in_beat_t beat;
    put_tag(MTHD_TAG);
    put_tag(HDR_LEN);
    sel = $urandom_range(19);
    f0  = 8'h00;
    if (sel == 0) begin
      f1 = 8'h00;
      case ($urandom_range(3))
        0:       hdr_tracks = 0;
        1:       hdr_tracks = 2;
        2:       hdr_tracks = 3;
        default: hdr_tracks = 16'hFFFF;
      endcase
    end else if (sel < 8) begin
      f1 = 8'h00;
      hdr_tracks = 1;
    end else begin
      f1 = 8'h01;
      hdr_tracks = $urandom_range(3);
    end
    if (sel == 19) begin
      f0 = ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(255));
      f1 = 8'($urandom_range(255));
    end
    div = 16'($urandom_range(16'hFFFF));
    put(f0);
    put(f1);
    put(hdr_tracks[15:8]);
    put(hdr_tracks[7:0]);
    put(div[15:8]);
    put(div[7:0]);
    body_tracks = (hdr_tracks > 3) ? 1 : hdr_tracks;
    if ($urandom_range(9) == 0) body_tracks++;
    repeat (body_tracks) begin
      put_tag(MTRK_TAG);
      repeat (4) put(8'($urandom_range(255)));
      repeat ($urandom_range(6)) put_event();
      put_track_end();
    end
    sel = $urandom_range(99);
    if (sel < 10) begin
      idx = $urandom_range(file_beats.size() - 1);
      beat = file_beats[idx];
      beat.data_byte = 8'($urandom_range(255));
      file_beats[idx] = beat;
    end else if (sel < 18) begin
      cut = $urandom_range(file_beats.size(), 1);
      while (file_beats.size() > cut) void'(file_beats.pop_back());
    end else if (sel < 22) begin
      repeat ($urandom_range(3, 1)) put(8'($urandom_range(255)));
    end
    finish_file();
  endtask

  task automatic build_noise();
    mfsp_pkg::in_beat_t beat;
    repeat ($urandom_range(12, 1)) begin
      beat.data_byte   = 8'($urandom_range(255));
      beat.end_of_file = ($urandom_range(5) == 0);
      file_beats.push_back(beat);
    end
    finish_file();
  endtask

  // called and returns at a falling edge
  task automatic send_beat(input mfsp_pkg::in_beat_t beat);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic drain_file_beats();
    while (file_beats.size() > 0) send_beat(file_beats.pop_front());
  endtask

  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int phase_no;
    in_valid = 1'b0;
    in_data  = '0;
    rst_n    = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // format 1, zero tracks, max division: clean end right after the header
    put_tag(MTHD_TAG);
    put_tag(HDR_LEN);
    put(8'h00);
    put(8'h01);
    put(8'h00);
    put(8'h00);
    put(8'hFF);
    put(8'hFF);
    finish_file();
    // wrong first marker byte on the last byte
    put(8'h00);
    finish_file();
    // bad header length on the last byte, which also ends the file
    put_tag(MTHD_TAG);
    put(8'h00);
    put(8'h00);
    put(8'h01);
    finish_file();
    // file cut after one marker byte
    put(MTHD_TAG[31:24]);
    finish_file();
    drain_file_beats();

    for (phase_no = 0; phase_no < 3; phase_no++) begin
      tx_idle_pct = (phase_no == 0) ? 32 : (phase_no == 1) ? 54 : 0;
      rx_idle_pct = (phase_no == 0) ? 54 : (phase_no == 1) ? 32 : 0;
      if (phase_no == 2) hold_go = 1'b1;
      while (beats_sent < (phase_no + 1) * PHASE_BEATS) begin
        if ($urandom_range(11) == 0) build_noise();
        else build_midi_file();
        drain_file_beats();
      end
      in_valid <= 1'b0;
      @(negedge clk);
      while (pending != 0) @(negedge clk);
    end

    repeat (20) @(negedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
